/* hdl/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and the block state setup for the ChaCha20 cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

   localparam int BlockBytes = 64;
   localparam int PosW       = $clog2(BlockBytes);
   localparam int CsrIdxW    = 3;

   localparam logic [31:0] Sigma0 = 32'h6170_7865;
   localparam logic [31:0] Sigma1 = 32'h3320_646e;
   localparam logic [31:0] Sigma2 = 32'h7962_2d32;
   localparam logic [31:0] Sigma3 = 32'h6b20_6574;

   localparam logic [CsrIdxW-1:0] CsrKeyA      = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrKeyB      = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrKeyC      = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrKeyD      = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrNonceLow  = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrNonceHigh = 3'd5;
   localparam logic [CsrIdxW-1:0] CsrInitCount = 3'd6;

   localparam logic [1:0] Rot16 = 2'd0;
   localparam logic [1:0] Rot12 = 2'd1;
   localparam logic [1:0] Rot8  = 2'd2;
   localparam logic [1:0] Rot7  = 2'd3;

   typedef struct packed {
      logic [7:0] data_in;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       end_of_message;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key_a;
      logic [63:0] key_b;
      logic [63:0] key_c;
      logic [63:0] key_d;
      logic [63:0] nonce_low;
      logic [31:0] nonce_high;
   } cfg_type;

   function automatic logic [31:0] init_word(cfg_type cfg, logic [31:0] counter,
                                             logic [3:0] idx);
      logic [31:0] w;
      unique case (idx)
         4'd0:    w = Sigma0;
         4'd1:    w = Sigma1;
         4'd2:    w = Sigma2;
         4'd3:    w = Sigma3;
         4'd4:    w = cfg.key_a[31:0];
         4'd5:    w = cfg.key_a[63:32];
         4'd6:    w = cfg.key_b[31:0];
         4'd7:    w = cfg.key_b[63:32];
         4'd8:    w = cfg.key_c[31:0];
         4'd9:    w = cfg.key_c[63:32];
         4'd10:   w = cfg.key_d[31:0];
         4'd11:   w = cfg.key_d[63:32];
         4'd12:   w = counter;
         4'd13:   w = cfg.nonce_low[31:0];
         4'd14:   w = cfg.nonce_low[63:32];
         default: w = cfg.nonce_high;
      endcase
      return w;
   endfunction

endpackage

/* hdl/chacha20_stream_cipher.sv */
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 byte stream cipher with key, nonce and start counter registers.
// ----------------------------------------------------------------------------
// Each word on the req channel carries one data byte and a last flag; the rsp
// channel returns the byte XORed with the next keystream byte and the flag.
// A word is taken when valid is high and stall is low on its channel.
// The csr channel writes key, nonce and start counter registers by index;
// csr_ready is always high and writes are expected while no byte is pending.
// A byte inside a keystream block goes through the output register to rsp,
// so such bytes stream at one per cycle while rsp does not stall.
// The first byte of a block starts the block function, which runs one
// add/xor/rotate step per cycle through the shared mix unit: 32 steps per
// double round, then 16 feed-forward steps. req_stall stays high from the
// time that byte is taken until its result enters the output register.
// When rsp is stalled the result holds in its output register; one more byte
// may be taken and then waits until the output register frees up.
// Reset clears key, nonce, start and block counters, byte position and message state.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher import cc20_pkg::*; #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_word,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [63:0]        csr_data
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_BLOCK = 3'b010,
      S_EMIT  = 3'b100
   } top_state_type;

   top_state_type   state_ff, state_in;
   cfg_type         cfg_ff;
   logic [31:0]     init_count_ff;
   logic [31:0]     block_count_ff, block_count_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic            msg_active_ff, msg_active_in;
   req_type         hold_ff, hold_in;
   rsp_type         rsp_word_ff, rsp_word_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            blk_start, blk_busy;
   logic [7:0]      ks_byte;
   logic            accept, need_block, out_free, load_out;
   req_type         cur;

   cc20_block #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_block (
      .clock    (clock),
      .reset    (reset),
      .start    (blk_start),
      .cfg      (cfg_ff),
      .counter  (block_count_in),
      .byte_sel (pos_ff),
      .busy     (blk_busy),
      .ks_byte  (ks_byte)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && (state_ff == S_IDLE);
   assign need_block = !msg_active_ff || (pos_ff == '0);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cur        = (state_ff == S_IDLE) ? req_word : hold_ff;

   always_comb begin
      state_in       = state_ff;
      hold_in        = hold_ff;
      block_count_in = block_count_ff;
      blk_start      = 1'b0;
      load_out       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               hold_in = req_word;
               if (need_block) begin
                  blk_start      = 1'b1;
                  block_count_in = msg_active_ff ? block_count_ff + 32'd1 : init_count_ff;
                  state_in       = S_BLOCK;
               end else if (out_free) begin
                  load_out = 1'b1;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_BLOCK: begin
            if (!blk_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      pos_in        = pos_ff;
      msg_active_in = msg_active_ff;
      if (load_out) begin
         rsp_word_in.data_out       = cur.data_in ^ ks_byte;
         rsp_word_in.end_of_message = cur.last;
         rsp_valid_in               = 1'b1;
         pos_in                     = cur.last ? '0 : pos_ff + 1'b1;
         msg_active_in              = !cur.last;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         pos_ff         <= '0;
         msg_active_ff  <= 1'b0;
         block_count_ff <= 32'd0;
         cfg_ff         <= '0;
         init_count_ff  <= 32'd0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         pos_ff         <= pos_in;
         msg_active_ff  <= msg_active_in;
         block_count_ff <= block_count_in;
         if (csr_valid) begin
            unique case (csr_index)
               CsrKeyA:      cfg_ff.key_a      <= csr_data;
               CsrKeyB:      cfg_ff.key_b      <= csr_data;
               CsrKeyC:      cfg_ff.key_c      <= csr_data;
               CsrKeyD:      cfg_ff.key_d      <= csr_data;
               CsrNonceLow:  cfg_ff.nonce_low  <= csr_data;
               CsrNonceHigh: cfg_ff.nonce_high <= csr_data[31:0];
               CsrInitCount: init_count_ff     <= csr_data[31:0];
               default: ;
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* hdl/cc20_mix.sv */
// ----------------------------------------------------------------------------
// cc20_mix
// Shared add, xor and rotate unit: sum = p + q, mixed = rotl(r ^ sum, n).
// ----------------------------------------------------------------------------
module cc20_mix import cc20_pkg::*; (
   input  logic [31:0] p,
   input  logic [31:0] q,
   input  logic [31:0] r,
   input  logic [1:0]  rot_sel,
   output logic [31:0] sum,
   output logic [31:0] mixed
);

   logic [31:0] x;

   assign sum = p + q;
   assign x   = r ^ sum;

   always_comb begin
      unique case (rot_sel)
         Rot16:   mixed = {x[15:0], x[31:16]};
         Rot12:   mixed = {x[19:0], x[31:20]};
         Rot8:    mixed = {x[23:0], x[31:24]};
         default: mixed = {x[24:0], x[31:25]};
      endcase
   end

endmodule

/* hdl/cc20_block.sv */
// ----------------------------------------------------------------------------
// cc20_block
// Block function sequencer: one add/xor/rotate step per cycle on column zero
// of the rotating state matrix, then a feed-forward add of the sixteen words.
// ----------------------------------------------------------------------------
module cc20_block import cc20_pkg::*; #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  cfg_type         cfg,
   input  logic [31:0]     counter,
   input  logic [PosW-1:0] byte_sel,
   output logic            busy,
   output logic [7:0]      ks_byte
);

   localparam int DrW = $clog2(DOUBLE_ROUNDS);

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_ROUND = 3'b010,
      B_FFWD  = 3'b100
   } blk_state_type;

   blk_state_type state_ff, state_in;
   logic [31:0]    w_ff [16];
   logic [31:0]    w_in [16];
   logic [31:0]    tmp [16];
   logic [4:0]     round_step_ff, round_step_in;
   logic [DrW-1:0] dround_ff, dround_in;
   logic [3:0]     ff_idx_ff, ff_idx_in;
   logic [1:0]     row_sh [4];
   logic [31:0]    mix_p, mix_q, mix_r, mix_sum, mix_out;
   logic [1:0]     rot_sel;
   logic [31:0]    ks_word;

   cc20_mix u_mix (
      .p       (mix_p),
      .q       (mix_q),
      .r       (mix_r),
      .rot_sel (rot_sel),
      .sum     (mix_sum),
      .mixed   (mix_out)
   );

   always_comb begin
      mix_p = w_ff[0];
      mix_q = w_ff[4];
      mix_r = w_ff[12];
      if (state_ff == B_FFWD) begin
         mix_q = init_word(cfg, counter, ff_idx_ff);
      end else if (round_step_ff[0]) begin
         mix_p = w_ff[8];
         mix_q = w_ff[12];
         mix_r = w_ff[4];
      end
      unique case (round_step_ff[1:0])
         2'd0:    rot_sel = Rot16;
         2'd1:    rot_sel = Rot12;
         2'd2:    rot_sel = Rot8;
         default: rot_sel = Rot7;
      endcase
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         row_sh[r] = 2'd0;
         if (round_step_ff[1:0] == 2'd3) begin
            if (round_step_ff[4:2] == 3'd3) begin
               row_sh[r] = 2'(r + 1);
            end else if (round_step_ff[4:2] == 3'd7) begin
               row_sh[r] = 2'(1 - r);
            end else begin
               row_sh[r] = 2'd1;
            end
         end
      end
   end

   always_comb begin
      tmp           = w_ff;
      w_in          = w_ff;
      state_in      = state_ff;
      round_step_in = round_step_ff;
      dround_in     = dround_ff;
      ff_idx_in     = ff_idx_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               for (int i = 0; i < 16; i++) begin
                  w_in[i] = init_word(cfg, counter, 4'(i));
               end
               round_step_in = 5'd0;
               dround_in     = '0;
               state_in      = B_ROUND;
            end
         end
         B_ROUND: begin
            if (round_step_ff[0]) begin
               tmp[8] = mix_sum;
               tmp[4] = mix_out;
            end else begin
               tmp[0]  = mix_sum;
               tmp[12] = mix_out;
            end
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 4; c++) begin
                  w_in[r*4 + c] = tmp[r*4 + int'(2'(c + row_sh[r]))];
               end
            end
            round_step_in = round_step_ff + 5'd1;
            if (round_step_ff == 5'd31) begin
               if (dround_ff == DrW'(DOUBLE_ROUNDS - 1)) begin
                  ff_idx_in = 4'd0;
                  state_in  = B_FFWD;
               end else begin
                  dround_in = dround_ff + 1'b1;
               end
            end
         end
         B_FFWD: begin
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15]  = mix_sum;
            ff_idx_in = ff_idx_ff + 4'd1;
            if (ff_idx_ff == 4'd15) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      if (reset) begin
         state_ff      <= B_IDLE;
         round_step_ff <= 5'd0;
         dround_ff     <= '0;
         ff_idx_ff     <= 4'd0;
      end else begin
         state_ff      <= state_in;
         round_step_ff <= round_step_in;
         dround_ff     <= dround_in;
         ff_idx_ff     <= ff_idx_in;
      end
   end

   assign busy    = (state_ff != B_IDLE);
   assign ks_word = w_ff[byte_sel[PosW-1:2]];
   assign ks_byte = ks_word[8*byte_sel[1:0] +: 8];

endmodule

/* dv/chacha20_checker.sv */
// ----------------------------------------------------------------------------
// chacha20_checker
// Watches the ChaCha20 cipher channels and checks every returned word.
// ----------------------------------------------------------------------------
// Register writes and accepted input bytes drive a local ChaCha20 keystream
// model. Each accepted input byte queues the expected output word, and each
// accepted output word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module chacha20_checker import cc20_pkg::*; #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  req_type            req_word,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rsp_type            rsp_word,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [63:0]        csr_data,
   output int                 fail_count,
   output int                 outstanding
);

   cfg_type      cfg;
   logic [31:0]  start_count;
   logic [31:0]  block_count;
   logic [PosW-1:0] byte_pos;
   logic         in_message;
   logic [511:0] keystream;
   rsp_type      expected_words[$];

   function automatic logic [31:0] rotate_left(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic logic [511:0] keystream_block(cfg_type c, logic [31:0] counter);
      logic [31:0]  start [16];
      logic [31:0]  x [16];
      logic [511:0] block;
      int           a, b, m, d, lane;
      start[0]  = Sigma0;
      start[1]  = Sigma1;
      start[2]  = Sigma2;
      start[3]  = Sigma3;
      start[4]  = c.key_a[31:0];
      start[5]  = c.key_a[63:32];
      start[6]  = c.key_b[31:0];
      start[7]  = c.key_b[63:32];
      start[8]  = c.key_c[31:0];
      start[9]  = c.key_c[63:32];
      start[10] = c.key_d[31:0];
      start[11] = c.key_d[63:32];
      start[12] = counter;
      start[13] = c.nonce_low[31:0];
      start[14] = c.nonce_low[63:32];
      start[15] = c.nonce_high;
      for (int i = 0; i < 16; i++) x[i] = start[i];
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         for (int q = 0; q < 8; q++) begin
            lane = q % 4;
            a = lane;
            if (q < 4) begin
               b = 4 + lane;
               m = 8 + lane;
               d = 12 + lane;
            end else begin
               b = 4 + (lane + 1) % 4;
               m = 8 + (lane + 2) % 4;
               d = 12 + (lane + 3) % 4;
            end
            x[a] = x[a] + x[b]; x[d] = rotate_left(x[d] ^ x[a], 16);
            x[m] = x[m] + x[d]; x[b] = rotate_left(x[b] ^ x[m], 12);
            x[a] = x[a] + x[b]; x[d] = rotate_left(x[d] ^ x[a], 8);
            x[m] = x[m] + x[d]; x[b] = rotate_left(x[b] ^ x[m], 7);
         end
      end
      for (int i = 0; i < 16; i++) block[32*i +: 32] = x[i] + start[i];
      return block;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         cfg         = '0;
         start_count = '0;
         block_count = '0;
         byte_pos    = '0;
         in_message  = 1'b0;
         keystream   = '0;
         fail_count  = 0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrKeyA:      cfg.key_a      = csr_data;
               CsrKeyB:      cfg.key_b      = csr_data;
               CsrKeyC:      cfg.key_c      = csr_data;
               CsrKeyD:      cfg.key_d      = csr_data;
               CsrNonceLow:  cfg.nonce_low  = csr_data;
               CsrNonceHigh: cfg.nonce_high = csr_data[31:0];
               CsrInitCount: start_count    = csr_data[31:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_word;
            if (expected_words.size() == 0) begin
               report_error($sformatf("unexpected word data_out=%02h end_of_message=%0b",
                                      got.data_out, got.end_of_message));
            end else begin
               want = expected_words.pop_front();
               if (got.data_out !== want.data_out)
                  report_error($sformatf("data_out got %02h want %02h",
                                         got.data_out, want.data_out));
               if (got.end_of_message !== want.end_of_message)
                  report_error($sformatf("end_of_message got %0b want %0b",
                                         got.end_of_message, want.end_of_message));
            end
         end
         if (req_valid && !req_stall) begin
            if (!in_message) begin
               block_count = start_count;
               byte_pos    = '0;
               in_message  = 1'b1;
            end
            if (byte_pos == '0) begin
               keystream   = keystream_block(cfg, block_count);
               block_count = block_count + 32'd1;
            end
            want.data_out       = req_word.data_in ^ keystream[8*byte_pos +: 8];
            want.end_of_message = req_word.last;
            expected_words.push_back(want);
            if (req_word.last) begin
               byte_pos   = '0;
               in_message = 1'b0;
            end else begin
               byte_pos = byte_pos + 1'b1;
            end
         end
      end
      outstanding = expected_words.size();
   end

endmodule

/* dv/tb_chacha20_stream_cipher.sv */
// ----------------------------------------------------------------------------
// tb_chacha20_stream_cipher
// Stimulus and verdict for the ChaCha20 byte stream cipher.
// ----------------------------------------------------------------------------
// Sends messages of random length and content under several key, nonce and
// start counter settings, including all-zero, all-one and counter wrap cases.
// Both channels idle at random, with one setting run without any idling.
// The checker beside the block predicts every output word and counts errors.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher;
   import cc20_pkg::*;

   localparam int DoubleRounds = 10;
   localparam int ItemTarget   = 1250;
   localparam int PhaseItems   = 220;
   localparam logic [CsrIdxW-1:0] CsrUnused = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_word;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_type            rsp_word;
   logic               csr_valid;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index;
   logic [63:0]        csr_data;
   int                 fail_count;
   int                 outstanding;
   logic               idle_on;
   int                 items_sent;

   chacha20_stream_cipher #(
      .DOUBLE_ROUNDS(DoubleRounds)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   chacha20_checker #(
      .DOUBLE_ROUNDS(DoubleRounds)
   ) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("chacha20_stream_cipher verification failed");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= idle_on && ($urandom_range(0, 99) < 11);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      @(negedge clock);
      while (idle_on && ($urandom_range(0, 99) < 11)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_word.data_in  <= data;
      req_word.last     <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all_regs(input cfg_type c, input logic [31:0] counter);
      write_csr(CsrKeyA, c.key_a);
      write_csr(CsrKeyB, c.key_b);
      write_csr(CsrKeyC, c.key_c);
      write_csr(CsrKeyD, c.key_d);
      write_csr(CsrNonceLow, c.nonce_low);
      write_csr(CsrNonceHigh, {32'($urandom), c.nonce_high});
      write_csr(CsrInitCount, {32'($urandom), counter});
   endtask

   initial begin
      cfg_type     setting;
      logic [31:0] counter;
      int          phase;
      int          phase_start;
      int          len;
      int          pick;
      logic        first;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_word   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      idle_on    = 1'b1;
      items_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'ha5, 1'b1);
      send_byte(8'h5a, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      drain_results();
      write_csr(CsrUnused, {$urandom, $urandom});
      write_all_regs('1, 32'hffff_ffff);
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h3c, 1'b1);
      send_byte(8'hc3, 1'b1);
      drain_results();
      write_all_regs('0, 32'h0000_0000);
      send_byte(8'h81, 1'b0);
      send_byte(8'h7e, 1'b1);

      phase = 0;
      while (items_sent < ItemTarget) begin
         drain_results();
         case (phase % 4)
            0: begin
               setting = '1;
               counter = 32'h0000_0000;
            end
            1: begin
               setting = '0;
               counter = 32'hffff_ffff;
            end
            default: begin
               setting.key_a      = {$urandom, $urandom};
               setting.key_b      = {$urandom, $urandom};
               setting.key_c      = {$urandom, $urandom};
               setting.key_d      = {$urandom, $urandom};
               setting.nonce_low  = {$urandom, $urandom};
               setting.nonce_high = $urandom;
               counter = ($urandom_range(0, 2) == 0) ? 32'hffff_fffe : 32'($urandom);
            end
         endcase
         idle_on = (phase != 2);
         write_all_regs(setting, counter);
         phase_start = items_sent;
         first       = 1'b1;
         while (items_sent - phase_start < PhaseItems && items_sent < ItemTarget) begin
            pick = $urandom_range(0, 3);
            if (first && (phase % 4 == 1 || counter == 32'hffff_fffe))
               len = 130;
            else if (pick == 0)
               len = $urandom_range(1, 4);
            else if (pick == 3)
               len = $urandom_range(60, 140);
            else
               len = $urandom_range(5, 80);
            first = 1'b0;
            send_message(len);
            if ($urandom_range(0, 9) == 0) drain_results();
         end
         phase++;
      end

      drain_results();
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("chacha20_stream_cipher verification clean");
      else
         $display("chacha20_stream_cipher verification failed");
      $finish;
   end

endmodule

/* sim.f */
hdl/cc20_pkg.sv
hdl/cc20_mix.sv
hdl/cc20_block.sv
hdl/chacha20_stream_cipher.sv
dv/chacha20_checker.sv
dv/tb_chacha20_stream_cipher.sv
